/* hdl/pfs_pkg.sv */
// ----------------------------------------------------------------------------
// pfs_pkg
// shared types and constants of the pairwise proportional fitting step unit
// ----------------------------------------------------------------------------
`default_nettype none

package pfs_pkg;

    localparam int PW       = 33;
    localparam int SW       = 44;
    localparam int QW       = 40;
    localparam int JW       = 32;
    localparam int LOG_FRAC = 24;
    localparam int DIV_BITS = 40;

    localparam logic [PW-1:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [QW-1:0] SCALE_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [SW-1:0] SUM_MAX   = 44'hFFF_FFFF_FFFF;
    localparam logic [31:0]   LN2_Q32   = 32'd2977044472;
    localparam logic [3:0]    NUM_VARS_RST = 4'd10;

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_EDGE = 2'd1,
        FUNC_READ = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_READ,
        RES_BADVAR,
        RES_ZMARG,
        RES_NEGSAT,
        RES_POSSAT,
        RES_J
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_NOP,
        S_RD1,
        S_RD2,
        S_EDGE,
        S_SUM,
        S_ZCHK,
        S_DLOAD,
        S_DIV,
        S_DSTORE,
        S_SCALE,
        S_CORNER,
        S_CCHK,
        S_NLOAD,
        S_NORM,
        S_LOG,
        S_LACC,
        S_JMUL,
        S_JRES,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic ram_load;
        logic ram_read;
        logic pass_clr;
        logic sum_run;
        logic scale_run;
        logic corner_run;
        logic div_clr;
        logic div_load;
        logic div_run;
        logic div_store;
        logic lacc_clr;
        logic norm_load;
        logic norm_run;
        logic log_load;
        logic log_run;
        logic lacc;
        logic jmul;
        logic res_set;
        t_res res_sel;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic bad_var;
        logic marg_zero;
        logic div_done;
        logic last_quad;
        logic pass_done;
        logic lo_zero;
        logic hi_zero;
        logic norm_done;
        logic it_done;
        logic last_corner;
    } t_sts;

endpackage

`default_nettype wire

/* hdl/pfs_if.sv */
// ----------------------------------------------------------------------------
// pfs channel interfaces
// valid/ready channels for items, results and the register write
// ----------------------------------------------------------------------------
`default_nettype none

interface pfs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [9:0]  entry_index;
    logic [32:0] prob_in;
    logic [3:0]  var_i;
    logic [3:0]  var_j;
    logic [32:0] emp_both_set;
    logic [32:0] emp_first_only;
    logic [32:0] emp_second_only;
    logic [32:0] emp_neither;

    modport source (output valid, func, entry_index, prob_in, var_i, var_j,
                    emp_both_set, emp_first_only, emp_second_only, emp_neither,
                    input ready);
    modport sink (input valid, func, entry_index, prob_in, var_i, var_j,
                  emp_both_set, emp_first_only, emp_second_only, emp_neither,
                  output ready);
endinterface

interface pfs_out_if;
    logic               valid;
    logic               ready;
    logic [32:0]        prob_out;
    logic signed [31:0] coupling;
    logic               edge_present;
    logic [1:0]         status;

    modport source (output valid, prob_out, coupling, edge_present, status,
                    input ready);
    modport sink (input valid, prob_out, coupling, edge_present, status,
                  output ready);
endinterface

interface pfs_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

/* hdl/pfs_ram.sv */
// ----------------------------------------------------------------------------
// pfs_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/pfs_ctrl.sv */
// ----------------------------------------------------------------------------
// pfs_ctrl
// sequencer for load, read and edge update items, and a no-op for other function codes
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_ctrl
    import pfs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_func,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_func'(i_func))
                        FUNC_LOAD: n_state = S_LOAD;
                        FUNC_EDGE: n_state = S_EDGE;
                        FUNC_READ: n_state = S_RD1;
                        default:   n_state = S_NOP;
                    endcase
                end
            end
            S_LOAD, S_NOP, S_RD2: n_state = S_DONE;
            S_RD1:    n_state = S_RD2;
            S_EDGE:   n_state = i_sts.bad_var ? S_DONE : S_SUM;
            S_SUM:    if (i_sts.pass_done) n_state = S_ZCHK;
            S_ZCHK:   n_state = i_sts.marg_zero ? S_DONE : S_DLOAD;
            S_DLOAD:  n_state = S_DIV;
            S_DIV:    if (i_sts.div_done) n_state = S_DSTORE;
            S_DSTORE: n_state = i_sts.last_quad ? S_SCALE : S_DLOAD;
            S_SCALE:  if (i_sts.pass_done) n_state = S_CORNER;
            S_CORNER: if (i_sts.pass_done) n_state = S_CCHK;
            S_CCHK:   n_state = (i_sts.lo_zero || i_sts.hi_zero) ? S_DONE : S_NLOAD;
            S_NLOAD:  n_state = S_NORM;
            S_NORM:   if (i_sts.norm_done) n_state = S_LOG;
            S_LOG:    if (i_sts.it_done) n_state = S_LACC;
            S_LACC:   n_state = i_sts.last_corner ? S_JMUL : S_NLOAD;
            S_JMUL:   n_state = S_JRES;
            S_JRES:   n_state = S_DONE;
            S_DONE:   if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.res_sel = RES_ZERO;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE:   o_cmd.capture = i_in_valid;
            S_LOAD: begin
                o_cmd.ram_load = 1'b1;
                o_cmd.res_set  = 1'b1;
            end
            S_NOP:    o_cmd.res_set = 1'b1;
            S_RD1:    o_cmd.ram_read = 1'b1;
            S_RD2: begin
                o_cmd.res_set = 1'b1;
                o_cmd.res_sel = RES_READ;
            end
            S_EDGE: begin
                if (i_sts.bad_var) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = RES_BADVAR;
                end else begin
                    o_cmd.pass_clr = 1'b1;
                end
            end
            S_SUM:    o_cmd.sum_run = 1'b1;
            S_ZCHK: begin
                if (i_sts.marg_zero) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = RES_ZMARG;
                end else begin
                    o_cmd.div_clr = 1'b1;
                end
            end
            S_DLOAD:  o_cmd.div_load = 1'b1;
            S_DIV:    o_cmd.div_run = 1'b1;
            S_DSTORE: begin
                o_cmd.div_store = 1'b1;
                o_cmd.pass_clr  = i_sts.last_quad;
            end
            S_SCALE: begin
                o_cmd.scale_run = 1'b1;
                o_cmd.pass_clr  = i_sts.pass_done;
            end
            S_CORNER: o_cmd.corner_run = 1'b1;
            S_CCHK: begin
                if (i_sts.lo_zero) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = RES_NEGSAT;
                end else if (i_sts.hi_zero) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = RES_POSSAT;
                end else begin
                    o_cmd.lacc_clr = 1'b1;
                end
            end
            S_NLOAD:  o_cmd.norm_load = 1'b1;
            S_NORM: begin
                o_cmd.norm_run = 1'b1;
                o_cmd.log_load = i_sts.norm_done;
            end
            S_LOG:    o_cmd.log_run = 1'b1;
            S_LACC:   o_cmd.lacc = 1'b1;
            S_JMUL:   o_cmd.jmul = 1'b1;
            S_JRES: begin
                o_cmd.res_set = 1'b1;
                o_cmd.res_sel = RES_J;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.push  = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted beat did not start work");

    a_done_free_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result not presented");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cmd.capture)
        else $error("capture while busy");

endmodule

`default_nettype wire

/* hdl/pfs_dp.sv */
// ----------------------------------------------------------------------------
// pfs_dp
// store, marginal sums, scale divider, rescale pipeline, log2 unit, results
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_dp
    import pfs_pkg::*;
#(
    parameter int MAX_VARS = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic               i_cfg_we,
    input  wire logic [3:0]         i_cfg_data,
    input  wire logic [9:0]         i_entry_index,
    input  wire logic [PW-1:0]      i_prob_in,
    input  wire logic [3:0]         i_var_i,
    input  wire logic [3:0]         i_var_j,
    input  wire logic [PW-1:0]      i_emp_both_set,
    input  wire logic [PW-1:0]      i_emp_first_only,
    input  wire logic [PW-1:0]      i_emp_second_only,
    input  wire logic [PW-1:0]      i_emp_neither,
    output logic [PW-1:0]           o_prob_out,
    output logic signed [JW-1:0]    o_coupling,
    output logic                    o_edge_present,
    output logic [1:0]              o_status
);

    localparam int AW = MAX_VARS;

    logic [3:0]      r_num_vars;
    logic [9:0]      r_idx;
    logic [PW-1:0]   r_prob;
    logic [3:0]      r_vi, r_vj;
    logic [PW-1:0]   r_emp [4];
    logic [SW-1:0]   r_sum [4];
    logic [QW-1:0]   r_scale [4];

    logic [AW:0]     r_cnt;
    logic            r_v1, r_v2;
    logic [AW-1:0]   r_a1, r_a2;
    logic [1:0]      r_c1;
    logic [64:0]     r_plo;
    logic [40:0]     r_phi;
    logic [PW-1:0]   r_corner [4];

    logic [1:0]      r_dq;
    logic            r_dsat;
    logic [SW-1:0]   r_rem;
    logic [39:0]     r_dsh;
    logic [QW-1:0]   r_q;
    logic [5:0]      r_dit;

    logic [1:0]      r_li;
    logic [PW-1:0]   r_z;
    logic [5:0]      r_k;
    logic [31:0]     r_y;
    logic [LOG_FRAC-1:0] r_frac;
    logic [4:0]      r_it;
    logic signed [32:0] r_lacc;
    logic [63:0]     r_jprod;

    logic [PW-1:0]   r_res_prob;
    logic [JW-1:0]   r_res_j;
    logic [1:0]      r_res_st;

    logic [4:0]      w_n, w_nv, w_vi, w_vj;
    logic [AW-1:0]   w_mi, w_mj, w_caddr;
    logic [AW:0]     w_len, w_lim;
    logic            w_issue, w_run;
    logic [PW-1:0]   w_rdata;
    logic [1:0]      w_q1;
    logic [SW:0]     w_acc;
    logic [41:0]     w_new_full;
    logic [PW-1:0]   w_new;
    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic [PW-1:0]   w_wdata, w_psat;
    logic [PW-1:0]   w_e;
    logic [SW-1:0]   w_s;
    logic [SW:0]     w_trial;
    logic            w_ge;
    logic            w_div_done;
    logic [63:0]     w_sq;
    logic [32:0]     w_t;
    logic [29:0]     w_l;
    logic [32:0]     w_mag33;
    logic [29:0]     w_jm;
    logic [JW-1:0]   w_j;

    function automatic logic [1:0] quad_of(input logic [AW-1:0] a,
                                           input logic [AW-1:0] mi,
                                           input logic [AW-1:0] mj);
        quad_of = {|(a & mi), |(a & mj)};
    endfunction

    // effective variable count and edge masks
    assign w_nv = {1'b0, r_num_vars};
    assign w_n  = (w_nv > 5'(MAX_VARS)) ? 5'(MAX_VARS) : w_nv;
    assign w_vi = {1'b0, r_vi};
    assign w_vj = {1'b0, r_vj};
    assign w_mi = AW'(1) << (w_n - w_vi);
    assign w_mj = AW'(1) << (w_n - w_vj);
    assign w_len = (AW+1)'(1) << w_n;

    assign o_sts.bad_var = (r_vi == 4'd0) || (w_vi > w_n) || (r_vj == 4'd0) ||
                           (w_vj > w_n) || (r_vi == r_vj);
    assign o_sts.marg_zero = (r_sum[0] == '0) || (r_sum[1] == '0) ||
                             (r_sum[2] == '0) || (r_sum[3] == '0);

    // streaming pass over the store
    assign w_run   = i_cmd.sum_run || i_cmd.scale_run || i_cmd.corner_run;
    assign w_lim   = i_cmd.corner_run ? (AW+1)'(4) : w_len;
    assign w_issue = w_run && (r_cnt < w_lim);
    assign o_sts.pass_done = (r_cnt == w_lim) && !r_v1 && !r_v2;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    w_caddr = '0;
            2'd1:    w_caddr = w_mi | w_mj;
            2'd2:    w_caddr = w_mi;
            default: w_caddr = w_mj;
        endcase
    end

    assign w_raddr = i_cmd.ram_read   ? AW'(r_idx) :
                     i_cmd.corner_run ? w_caddr : r_cnt[AW-1:0];

    assign w_q1  = quad_of(r_a1, w_mi, w_mj);
    assign w_acc = {1'b0, r_sum[w_q1]} + (SW+1)'(w_rdata);

    assign w_new_full = {1'b0, r_phi} + 42'(r_plo[64:32]);
    assign w_new = (w_new_full > 42'(ONE_Q32)) ? ONE_Q32 : w_new_full[PW-1:0];
    assign w_psat = (r_prob > ONE_Q32) ? ONE_Q32 : r_prob;

    assign w_we    = i_cmd.ram_load || r_v2;
    assign w_waddr = i_cmd.ram_load ? AW'(r_idx) : r_a2;
    assign w_wdata = i_cmd.ram_load ? w_psat : w_new;

    pfs_ram #(
        .WIDTH (PW),
        .DEPTH (1 << MAX_VARS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // restoring divider for the scale factors
    assign w_e     = r_emp[r_dq];
    assign w_s     = r_sum[r_dq];
    assign w_trial = {r_rem, r_dsh[39]};
    assign w_ge    = w_trial >= {1'b0, w_s};
    assign w_div_done = r_dsat || (r_dit == 6'(DIV_BITS));
    assign o_sts.div_done  = w_div_done;
    assign o_sts.last_quad = (r_dq == 2'd3);

    // log2 by normalization and repeated squaring
    assign w_sq = r_y * r_y;
    assign w_t  = w_sq[63:31];
    assign w_l  = {r_k[5:0], r_frac};
    assign o_sts.norm_done   = r_z[32];
    assign o_sts.it_done     = (r_it == 5'(LOG_FRAC));
    assign o_sts.last_corner = (r_li == 2'd3);
    assign o_sts.lo_zero = (r_corner[0] == '0) || (r_corner[1] == '0);
    assign o_sts.hi_zero = (r_corner[2] == '0) || (r_corner[3] == '0);

    assign w_mag33 = r_lacc[32] ? 33'(-r_lacc) : 33'(r_lacc);
    assign w_jm    = r_jprod[63:34];
    assign w_j     = r_lacc[32] ? -JW'(w_jm) : JW'(w_jm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vars <= NUM_VARS_RST;
            r_cnt      <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_vars <= i_cfg_data;
            end
            if (i_cmd.pass_clr) begin
                r_cnt <= '0;
            end else if (w_issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_v1 <= w_issue;
            r_v2 <= r_v1 && i_cmd.scale_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx    <= i_entry_index;
            r_prob   <= i_prob_in;
            r_vi     <= i_var_i;
            r_vj     <= i_var_j;
            r_emp[3] <= i_emp_both_set;
            r_emp[2] <= i_emp_first_only;
            r_emp[1] <= i_emp_second_only;
            r_emp[0] <= i_emp_neither;
            for (int k = 0; k < 4; k++) begin
                r_sum[k] <= '0;
            end
        end else if (r_v1 && i_cmd.sum_run) begin
            r_sum[w_q1] <= w_acc[SW] ? SUM_MAX : w_acc[SW-1:0];
        end

        r_a1  <= r_cnt[AW-1:0];
        r_c1  <= r_cnt[1:0];
        r_a2  <= r_a1;
        r_plo <= w_rdata * r_scale[w_q1][31:0];
        r_phi <= w_rdata * r_scale[w_q1][QW-1:32];
        if (r_v1 && i_cmd.corner_run) begin
            r_corner[r_c1] <= w_rdata;
        end

        if (i_cmd.div_clr) begin
            r_dq <= '0;
        end else if (i_cmd.div_store) begin
            r_scale[r_dq] <= r_dsat ? SCALE_MAX : r_q;
            r_dq <= r_dq + 1'b1;
        end
        if (i_cmd.div_load) begin
            r_dsat <= {19'b0, w_e} >= {w_s, 8'b0};
            r_rem  <= SW'(w_e >> 8);
            r_dsh  <= {w_e[7:0], 32'b0};
            r_q    <= '0;
            r_dit  <= '0;
        end else if (i_cmd.div_run && !w_div_done) begin
            r_rem <= w_ge ? SW'(w_trial - {1'b0, w_s}) : SW'(w_trial);
            r_q   <= {r_q[QW-2:0], w_ge};
            r_dsh <= {r_dsh[38:0], 1'b0};
            r_dit <= r_dit + 1'b1;
        end

        if (i_cmd.norm_load) begin
            r_z <= r_corner[r_li];
            r_k <= 6'd32;
        end else if (i_cmd.norm_run && !r_z[32]) begin
            r_z <= {r_z[31:0], 1'b0};
            r_k <= r_k - 1'b1;
        end
        if (i_cmd.log_load) begin
            r_y    <= r_z[32:1];
            r_frac <= '0;
            r_it   <= '0;
        end else if (i_cmd.log_run && (r_it != 5'(LOG_FRAC))) begin
            r_y    <= w_t[32] ? w_t[32:1] : w_t[31:0];
            r_frac <= {r_frac[LOG_FRAC-2:0], w_t[32]};
            r_it   <= r_it + 1'b1;
        end
        if (i_cmd.lacc_clr) begin
            r_lacc <= '0;
            r_li   <= '0;
        end else if (i_cmd.lacc) begin
            r_lacc <= r_li[1] ? r_lacc - $signed({3'b0, w_l})
                              : r_lacc + $signed({3'b0, w_l});
            r_li   <= r_li + 1'b1;
        end
        if (i_cmd.jmul) begin
            r_jprod <= w_mag33[31:0] * LN2_Q32;
        end

        if (i_cmd.res_set) begin
            r_res_prob <= '0;
            r_res_j    <= '0;
            r_res_st   <= 2'd0;
            case (i_cmd.res_sel)
                RES_READ:   r_res_prob <= w_rdata;
                RES_BADVAR: r_res_st   <= 2'd2;
                RES_ZMARG:  r_res_st   <= 2'd1;
                RES_NEGSAT: begin
                    r_res_j  <= 32'h8000_0000;
                    r_res_st <= 2'd1;
                end
                RES_POSSAT: begin
                    r_res_j  <= 32'h7FFF_FFFF;
                    r_res_st <= 2'd1;
                end
                RES_J:      r_res_j <= w_j;
                default: ;
            endcase
        end
        if (i_cmd.push) begin
            o_prob_out     <= r_res_prob;
            o_coupling     <= $signed(r_res_j);
            o_edge_present <= (r_res_j != '0);
            o_status       <= r_res_st;
        end
    end

    a_wb_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (w_wdata <= ONE_Q32))
        else $error("rescaled entry above one");

    a_rem_below_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_run && !r_dsat) |-> (r_rem < w_s))
        else $error("divider remainder out of range");

    a_log_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.log_run |-> r_y[31])
        else $error("log mantissa lost normalization");

endmodule

`default_nettype wire

/* hdl/pairwise_proportional_fitting_step_unit.sv */
// ----------------------------------------------------------------------------
// pairwise_proportional_fitting_step_unit
// fixed point pairwise proportional fitting over a binary joint distribution
// ----------------------------------------------------------------------------
// One item at a time, one result beat per item. The time an edge update takes
// is set by the two single-port-read passes over the probability store, the
// bit-serial scale divider (up to 40 steps per quadrant) and the log2 unit
// (up to 32 normalize steps plus 24 squaring steps per corner). A new item
// is accepted while the previous result beat still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module pairwise_proportional_fitting_step_unit
    import pfs_pkg::*;
#(
    parameter int MAX_VARS = 10
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pfs_in_if.sink     i_in,
    pfs_out_if.source  o_out,
    pfs_cfg_if.sink    i_cfg
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign i_cfg.ready = 1'b1;

    pfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_func      (i_in.func),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    pfs_dp #(
        .MAX_VARS (MAX_VARS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_data        (i_cfg.data),
        .i_entry_index     (i_in.entry_index),
        .i_prob_in         (i_in.prob_in),
        .i_var_i           (i_in.var_i),
        .i_var_j           (i_in.var_j),
        .i_emp_both_set    (i_in.emp_both_set),
        .i_emp_first_only  (i_in.emp_first_only),
        .i_emp_second_only (i_in.emp_second_only),
        .i_emp_neither     (i_in.emp_neither),
        .o_prob_out        (o_out.prob_out),
        .o_coupling        (o_out.coupling),
        .o_edge_present    (o_out.edge_present),
        .o_status          (o_out.status)
    );

endmodule

`default_nettype wire
